FILE: rtl/core/integer_elementwise_alu_macros.svh
// ---------------------------------------------------------------------------
// Integer elementwise ALU assertion macros
// Shared concurrent assertion forms used by the ALU top level.
// ---------------------------------------------------------------------------
`ifndef INTEGER_ELEMENTWISE_ALU_MACROS_SVH
`define INTEGER_ELEMENTWISE_ALU_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define IEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked also across reset
`define IEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/iea_pkg.sv
// ---------------------------------------------------------------------------
// Integer elementwise ALU package
// Types, operation codes, register indexes and helper functions.
// ---------------------------------------------------------------------------
package iea_pkg;

  localparam int DataW = 64;
  localparam int WidthW = 7;

  // Operation codes
  localparam logic [2:0] OP_DIV  = 3'd0;
  localparam logic [2:0] OP_REM  = 3'd1;
  localparam logic [2:0] OP_SHL  = 3'd2;
  localparam logic [2:0] OP_SHR  = 3'd3;
  localparam logic [2:0] OP_SRA  = 3'd4;
  localparam logic [2:0] OP_POPC = 3'd5;
  localparam logic [2:0] OP_CLZ  = 3'd6;

  // Configuration register indexes
  localparam logic REG_LOGICAL_BITS = 1'b0;
  localparam logic REG_IS_SIGNED    = 1'b1;

  localparam logic [WidthW-1:0] LOGICAL_BITS_RST = 7'd32;

  // Side information travelling with each item through the divider chain
  typedef struct packed {
    logic [2:0]       func;
    logic             dz;
    logic             an;
    logic             bn;
    logic             sq;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [DataW-1:0] alt;
    logic [DataW-1:0] mask;
  } iea_side_t;

  // One divider cell's contents: partial remainder, dividend/quotient word
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dq;
    iea_side_t        side;
  } iea_stage_t;

  // Round the width request up to a supported width
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] bits);
    logic [WidthW-1:0] w;
    if (bits <= 7'd2)       w = 7'd2;
    else if (bits <= 7'd4)  w = 7'd4;
    else if (bits <= 7'd8)  w = 7'd8;
    else if (bits <= 7'd16) w = 7'd16;
    else if (bits <= 7'd32) w = 7'd32;
    else                    w = 7'd64;
    return w;
  endfunction

  function automatic logic [DataW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [DataW-1:0] m;
    if (w >= 7'd64) m = '1;
    else            m = (64'd1 << w[5:0]) - 64'd1;
    return m;
  endfunction

endpackage

FILE: rtl/core/iea_front.sv
// ---------------------------------------------------------------------------
// Integer elementwise ALU front stage
// Masks and signs the operands, computes shifts and counts, loads the chain.
// ---------------------------------------------------------------------------
module iea_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [iea_pkg::WidthW-1:0] cfg_bits,
  input  logic                       cfg_signed,
  input  logic [2:0]                 func,
  input  logic [iea_pkg::DataW-1:0]  op_a,
  input  logic [iea_pkg::DataW-1:0]  op_b,
  output logic                       valid_o,
  output iea_pkg::iea_stage_t        stage_o
);
  import iea_pkg::*;

  logic              valid_r;
  iea_stage_t        stage_r;
  iea_stage_t        stage_nxt;
  logic [WidthW-1:0] w;
  logic [DataW-1:0]  m, topb, am, bm, av, bv, sa, smear, alt;
  logic              a_top, b_top, an, bn, aw, bw, amt_ge;
  logic [WidthW-1:0] pc_a, pc_s;

  always_comb begin
    w     = eff_width(cfg_bits);
    m     = width_mask(w);
    topb  = m ^ (m >> 1);
    am    = op_a & m;
    bm    = op_b & m;
    a_top = |(op_a & topb);
    b_top = |(op_b & topb);
    sa    = a_top ? (op_a | ~m) : am;
    av    = sa;
    bv    = b_top ? (op_b | ~m) : bm;
    an    = cfg_signed & a_top;
    bn    = cfg_signed & b_top;
    amt_ge = bm >= {57'd0, w};
    // smear leading one downwards for the zero count
    smear = am;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 32);
    pc_a  = WidthW'($countones(am));
    pc_s  = WidthW'($countones(smear));

    // non-divide results
    case (func)
      OP_SHL:  alt = amt_ge ? '0 : (op_a << bm[5:0]);
      OP_SHR:  alt = amt_ge ? '0 : (am >> bm[5:0]);
      OP_SRA:  alt = amt_ge ? {DataW{a_top}} : DataW'($signed(sa) >>> bm[5:0]);
      OP_POPC: alt = {57'd0, pc_a};
      OP_CLZ:  alt = {57'd0, w - pc_s};
      default: alt = '0;
    endcase

    // magnitudes and quotient sign
    stage_nxt.side.func = func;
    stage_nxt.side.dz   = (func == OP_DIV || func == OP_REM) && (bm == '0);
    stage_nxt.side.an   = an;
    stage_nxt.side.bn   = bn;
    stage_nxt.side.ma   = an ? (64'd0 - av) : am;
    stage_nxt.side.mb   = bn ? (64'd0 - bv) : bm;
    aw = (w >= 7'd8) && an && ((stage_nxt.side.ma & m) == topb);
    bw = (w >= 7'd8) && bn && ((stage_nxt.side.mb & m) == topb);
    stage_nxt.side.sq   = an ^ bn ^ aw ^ bw;
    stage_nxt.side.alt  = alt;
    stage_nxt.side.mask = m;
    stage_nxt.rem       = '0;
    stage_nxt.dq        = stage_nxt.side.ma;
  end

  // Load the head of the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

FILE: rtl/core/iea_div_cell.sv
// ---------------------------------------------------------------------------
// Integer elementwise ALU divider cell
// One restoring division step; hands its item to the next cell.
// ---------------------------------------------------------------------------
module iea_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  iea_pkg::iea_stage_t stage_i,
  output logic                valid_o,
  output iea_pkg::iea_stage_t stage_o
);
  import iea_pkg::*;

  logic             valid_r;
  iea_stage_t       stage_r;
  iea_stage_t       stage_nxt;
  logic [DataW+1:0] diff;
  logic             ge;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    diff = {1'b0, stage_i.rem, stage_i.dq[DataW-1]} - {2'b00, stage_i.side.mb};
    ge   = !diff[DataW+1];
    stage_nxt      = stage_i;
    stage_nxt.rem  = ge ? diff[DataW-1:0] : {stage_i.rem[DataW-2:0], stage_i.dq[DataW-1]};
    stage_nxt.dq   = {stage_i.dq[DataW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

FILE: rtl/core/iea_finish.sv
// ---------------------------------------------------------------------------
// Integer elementwise ALU finish stages
// Signs quotient and remainder, selects the result and holds the output.
// ---------------------------------------------------------------------------
module iea_finish (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  iea_pkg::iea_stage_t       stage_i,
  output logic                      out_valid,
  output logic [iea_pkg::DataW-1:0] out_result,
  output logic                      out_dz
);
  import iea_pkg::*;

  logic             f1_valid_r;
  logic [2:0]       f1_func_r;
  logic             f1_dz_r, f1_add_r;
  logic [DataW-1:0] f1_mask_r, f1_alt_r, f1_q_r, f1_t_r, f1_sa_r;
  logic             out_valid_r, out_dz_r;
  logic [DataW-1:0] out_result_r, rem, res_nxt;

  // First stage: signed quotient, magnitude product and signed dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= valid_i;
    end
    if (en) begin
      f1_func_r <= stage_i.side.func;
      f1_dz_r   <= stage_i.side.dz;
      f1_mask_r <= stage_i.side.mask;
      f1_alt_r  <= stage_i.side.alt;
      f1_q_r    <= stage_i.side.sq ? (64'd0 - stage_i.dq) : stage_i.dq;
      f1_t_r    <= stage_i.side.ma - stage_i.rem;
      f1_sa_r   <= stage_i.side.an ? (64'd0 - stage_i.side.ma) : stage_i.side.ma;
      f1_add_r  <= stage_i.side.sq ^ stage_i.side.bn;
    end
  end

  // Second stage: remainder as a minus q times b, pick the result
  always_comb begin
    rem = f1_add_r ? (f1_sa_r + f1_t_r) : (f1_sa_r - f1_t_r);
    if (f1_dz_r) begin
      res_nxt = '0;
    end else begin
      case (f1_func_r)
        OP_DIV:  res_nxt = f1_q_r;
        OP_REM:  res_nxt = rem;
        default: res_nxt = f1_alt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_valid_r;
    end
    if (en) begin
      out_result_r <= res_nxt & f1_mask_r;
      out_dz_r     <= f1_dz_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_dz     = out_dz_r;

endmodule

FILE: rtl/core/integer_elementwise_alu.sv
// Each input passes the front stage, the 64 divider cells and the finish stages to the output port.
// Throughput: one item per cycle unless the output stalls; the 64-cell divider chain is fully pipelined.
// The whole chain advances together and holds while the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline, sets logical_bits
// to 32 and is_signed to 1.
// ---------------------------------------------------------------------------
// Integer elementwise ALU
// Divide, remainder, shifts and counts at a configurable logical width.
// ---------------------------------------------------------------------------
`include "integer_elementwise_alu_macros.svh"

module integer_elementwise_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // operand_a [63:0], operand_b [127:64]
  input  logic [2:0]   in_tuser,   // func [2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // result [63:0]
  output logic         out_tuser   // div_by_zero [0]
);
  import iea_pkg::*;

  logic [WidthW-1:0] bits_r;
  logic              signed_r;
  logic              en;
  logic [DataW-1:0]  lane_mask;
  logic              valid_c [DataW+1];
  iea_stage_t        stage_c [DataW+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= LOGICAL_BITS_RST;
      signed_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOGICAL_BITS: bits_r   <= cfg_wdata;
        REG_IS_SIGNED:    signed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Mask of the current logical width
  assign lane_mask = width_mask(eff_width(bits_r));

  // Advance the whole pipeline unless the output holds a stalled result
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  iea_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .cfg_bits   (bits_r),
    .cfg_signed (signed_r),
    .func       (in_tuser),
    .op_a       (in_tdata[63:0]),
    .op_b       (in_tdata[127:64]),
    .valid_o    (valid_c[0]),
    .stage_o    (stage_c[0])
  );

  // Divider chain, one quotient bit per cell, most significant first
  for (genvar i = 0; i < DataW; i++) begin : g_cell
    iea_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_c[i]),
      .stage_i (stage_c[i]),
      .valid_o (valid_c[i+1]),
      .stage_o (stage_c[i+1])
    );
  end

  iea_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_i    (valid_c[DataW]),
    .stage_i    (stage_c[DataW]),
    .out_valid  (out_tvalid),
    .out_result (out_tdata),
    .out_dz     (out_tuser)
  );

  // Checks
  `IEA_ASSERT_NOW(a_dz_zero, out_tvalid && out_tuser, out_tdata == 64'd0, "dz with nonzero result")
  `IEA_ASSERT_NOW(a_wrapped, out_tvalid, (out_tdata & ~lane_mask) == 64'd0, "result too wide")
  `IEA_ASSERT_NEXT(a_rst_cfg, !rst_n, bits_r == LOGICAL_BITS_RST && signed_r && !out_tvalid, "bad reset")

endmodule
